[hdl/icy_md_pkg.sv]
`default_nettype none

package icy_md_pkg;

   // Title storage: two banks (published and staging) of TITLE_CAP bytes.
   // The store is split by address parity so two consecutive characters
   // can be written in the same cycle.
   localparam int TITLE_CAP   = 256;
   localparam int LEN_W       = $clog2(TITLE_CAP);
   localparam int HALF_W      = LEN_W - 1;
   localparam int STORE_AW    = HALF_W + 1;
   localparam int STORE_DEPTH = 2 * (TITLE_CAP / 2);

   localparam logic [LEN_W-1:0] CAP_MAX = LEN_W'(TITLE_CAP - 1);

   localparam int INTERVAL_W = 24;
   localparam int REMAIN_W   = 12;

   localparam logic [3:0] KEY_LEN = 4'd13;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_QUOTE = 8'h27;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_S     = 8'h53;

   localparam logic OP_BODY = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [3:0] {
      PH_SEARCH  = 4'b0001,
      PH_CAPTURE = 4'b0010,
      PH_FOUND   = 4'b0100,
      PH_NONE    = 4'b1000
   } scan_phase_type;

   typedef struct packed {
      scan_phase_type   phase;
      logic [3:0]       key_pos;
      logic             quote_pending;
      logic [LEN_W-1:0] cap_len;
   } scan_type;

   localparam scan_type SCAN_IDLE = '{
      phase:         PH_SEARCH,
      key_pos:       4'd0,
      quote_pending: 1'b0,
      cap_len:       '0
   };

   // Write request into the parity-split title store
   typedef struct packed {
      logic              bank;
      logic              even_en;
      logic [HALF_W-1:0] even_half;
      logic [7:0]        even_data;
      logic              odd_en;
      logic [HALF_W-1:0] odd_half;
      logic [7:0]        odd_data;
   } title_wr_type;

   // "StreamTitle='"
   function automatic logic [7:0] key_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h53;
         4'd1:    c = 8'h74;
         4'd2:    c = 8'h72;
         4'd3:    c = 8'h65;
         4'd4:    c = 8'h61;
         4'd5:    c = 8'h6D;
         4'd6:    c = 8'h54;
         4'd7:    c = 8'h69;
         4'd8:    c = 8'h74;
         4'd9:    c = 8'h6C;
         4'd10:   c = 8'h65;
         4'd11:   c = 8'h3D;
         4'd12:   c = 8'h27;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[hdl/icy_md_scan.sv]
`default_nettype none

module icy_md_scan
   import icy_md_pkg::*;
(
   input  var scan_type     scan_cur,
   input  wire logic [7:0]  data_byte,
   input  wire logic        block_end,
   input  wire logic        stage_bank,
   output var scan_type     scan_nxt,
   output var title_wr_type title_wr,
   output logic             title_found
);

   logic [1:0]       push_cnt;
   logic [7:0]       push_c0;
   logic             en0;
   logic             en1;
   logic [LEN_W-1:0] len;

   always_comb begin
      scan_nxt = scan_cur;
      push_cnt = 2'd0;
      push_c0  = CHAR_QUOTE;
      len      = scan_cur.cap_len;

      unique case (scan_cur.phase)
         PH_SEARCH: begin
            if (data_byte == CHAR_NUL) begin
               scan_nxt.phase = PH_NONE;
            end else if (scan_cur.key_pos < KEY_LEN &&
                         data_byte == key_char(scan_cur.key_pos)) begin
               scan_nxt.key_pos = scan_cur.key_pos + 4'd1;
               if (scan_cur.key_pos + 4'd1 == KEY_LEN) begin
                  scan_nxt.phase = PH_CAPTURE;
               end
            end else begin
               scan_nxt.key_pos = (data_byte == CHAR_S) ? 4'd1 : 4'd0;
            end
         end
         PH_CAPTURE: begin
            if (data_byte == CHAR_NUL) begin
               push_cnt = scan_cur.quote_pending ? 2'd1 : 2'd0;
               scan_nxt.quote_pending = 1'b0;
               scan_nxt.phase = PH_FOUND;
            end else if (scan_cur.quote_pending) begin
               if (data_byte == CHAR_SEMI) begin
                  scan_nxt.quote_pending = 1'b0;
                  scan_nxt.phase = PH_FOUND;
               end else if (data_byte == CHAR_QUOTE) begin
                  push_cnt = 2'd1;
               end else begin
                  // held quote, then this character
                  push_cnt = 2'd2;
                  scan_nxt.quote_pending = 1'b0;
               end
            end else if (data_byte == CHAR_QUOTE) begin
               scan_nxt.quote_pending = 1'b1;
            end else begin
               push_cnt = 2'd1;
               push_c0  = data_byte;
            end
         end
         PH_FOUND, PH_NONE: begin
            scan_nxt = scan_cur;
         end
         default: begin
            scan_nxt = scan_cur;
         end
      endcase

      title_found = (scan_nxt.phase == PH_CAPTURE) || (scan_nxt.phase == PH_FOUND);

      // a quote still held at block end is kept
      if (block_end && title_found && scan_nxt.quote_pending) begin
         push_cnt = push_cnt + 2'd1;
      end

      en0 = (push_cnt != 2'd0) && (len != CAP_MAX);
      en1 = (push_cnt == 2'd2) && (len < CAP_MAX - LEN_W'(1));
      scan_nxt.cap_len = len + LEN_W'(en0) + LEN_W'(en1);

      // second character is always the input byte (or a quote equal to it)
      title_wr.bank = stage_bank;
      if (!len[0]) begin
         title_wr.even_en   = en0;
         title_wr.even_half = len[LEN_W-1:1];
         title_wr.even_data = push_c0;
         title_wr.odd_en    = en1;
         title_wr.odd_half  = len[LEN_W-1:1];
         title_wr.odd_data  = data_byte;
      end else begin
         title_wr.odd_en    = en0;
         title_wr.odd_half  = len[LEN_W-1:1];
         title_wr.odd_data  = push_c0;
         title_wr.even_en   = en1;
         title_wr.even_half = len[LEN_W-1:1] + HALF_W'(1);
         title_wr.even_data = data_byte;
      end
   end

endmodule

`default_nettype wire

[hdl/icy_md_title_store.sv]
`default_nettype none

module icy_md_title_store
   import icy_md_pkg::*;
(
   input  wire logic             clock,
   input  var title_wr_type      title_wr,
   input  wire logic             wr_go,
   input  wire logic             rd_en,
   input  wire logic             rd_bank,
   input  wire logic [LEN_W-1:0] rd_index,
   output logic [7:0]            rd_char
);

   logic [7:0] even_mem [STORE_DEPTH];
   logic [7:0] odd_mem  [STORE_DEPTH];

   logic [7:0] even_q_ff;
   logic [7:0] odd_q_ff;
   logic       odd_sel_ff;

   always_ff @(posedge clock) begin
      if (wr_go && title_wr.even_en) begin
         even_mem[{title_wr.bank, title_wr.even_half}] <= title_wr.even_data;
      end
      if (wr_go && title_wr.odd_en) begin
         odd_mem[{title_wr.bank, title_wr.odd_half}] <= title_wr.odd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         even_q_ff  <= even_mem[{rd_bank, rd_index[LEN_W-1:1]}];
         odd_q_ff   <= odd_mem[{rd_bank, rd_index[LEN_W-1:1]}];
         odd_sel_ff <= rd_index[0];
      end
   end

   assign rd_char = odd_sel_ff ? odd_q_ff : even_q_ff;

endmodule

`default_nettype wire

[hdl/icy_metadata_demux_core.sv]
`default_nettype none

// ICY metadata demultiplexer. Each request carries either a stream body
// byte (op 0) or a title read (op 1) and produces exactly one response.
// With csr_wr_data nonzero, every csr_wr_data audio bytes are followed by a
// length byte L and then L*16 metadata bytes; the first StreamTitle=' in a
// block is captured (up to the quote-semicolon, a NUL or the block end,
// at most 255 characters) into a staging bank, and at block end a found
// title is published by swapping banks (rsp_title_updated). A read returns
// the published character at req_title_index, 0 past rsp_title_length.
// Throughput is one request per cycle while responses are taken; a request
// passes the input register and then the response register, with the title
// store read registered alongside it. Writing the interval reloads the
// audio countdown; write it only while no request is in flight.
module icy_metadata_demux_core
   import icy_md_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  csr_wr_en,
   input  wire logic [INTERVAL_W-1:0] csr_wr_data,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic [7:0]            req_title_index,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_audio_valid,
   output logic [7:0]                 rsp_audio_byte,
   output logic                       rsp_in_metadata,
   output logic                       rsp_title_updated,
   output logic [7:0]                 rsp_title_length,
   output logic [7:0]                 rsp_title_char
);

   // input register
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;
   logic [7:0] in_index_ff;

   // stream state
   logic [INTERVAL_W-1:0] meta_interval_ff;
   logic [INTERVAL_W-1:0] countdown_ff, countdown_in;
   logic [REMAIN_W-1:0]   remaining_ff, remaining_in;
   scan_type              scan_ff, scan_in;
   logic                  pub_bank_ff, pub_bank_in;
   logic [LEN_W-1:0]      pub_len_ff, pub_len_in;

   // response register
   logic       rsp_valid_ff;
   logic       audio_valid_ff;
   logic [7:0] audio_byte_ff;
   logic       in_meta_ff;
   logic       updated_ff;
   logic [7:0] title_len_ff;
   logic       char_ok_ff;

   logic out_take;
   logic step;
   logic is_body;
   logic in_block;
   logic block_end;
   logic len_byte;
   logic audio_in;
   logic updated_in;

   scan_type     scan_nxt;
   title_wr_type title_wr;
   logic         title_found;
   logic [7:0]   store_char;

   // handshake: the response register frees the input register
   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_take;
   assign req_ready = !in_valid_ff || out_take;

   assign is_body   = (in_op_ff == OP_BODY);
   assign in_block  = (remaining_ff != '0);
   assign block_end = (remaining_ff == REMAIN_W'(1));
   assign len_byte  = (meta_interval_ff != '0) && (countdown_ff == '0);
   assign audio_in  = is_body && !in_block && !len_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff    <= req_op;
         in_byte_ff  <= req_data_byte;
         in_index_ff <= req_title_index;
      end
   end

   icy_md_scan u_scan (
      .scan_cur    (scan_ff),
      .data_byte   (in_byte_ff),
      .block_end   (block_end),
      .stage_bank  (~pub_bank_ff),
      .scan_nxt    (scan_nxt),
      .title_wr    (title_wr),
      .title_found (title_found)
   );

   always_comb begin
      countdown_in = countdown_ff;
      remaining_in = remaining_ff;
      scan_in      = scan_ff;
      pub_bank_in  = pub_bank_ff;
      pub_len_in   = pub_len_ff;
      updated_in   = 1'b0;

      if (step && is_body) begin
         if (in_block) begin
            remaining_in = remaining_ff - REMAIN_W'(1);
            scan_in      = scan_nxt;
            if (block_end) begin
               if (title_found) begin
                  pub_bank_in = ~pub_bank_ff;
                  pub_len_in  = scan_nxt.cap_len;
                  updated_in  = 1'b1;
               end
               scan_in      = SCAN_IDLE;
               countdown_in = meta_interval_ff;
            end
         end else if (len_byte) begin
            remaining_in = {in_byte_ff, 4'b0000};
            scan_in      = SCAN_IDLE;
            if (in_byte_ff == 8'd0) begin
               // empty block: straight back to audio
               countdown_in = meta_interval_ff;
            end
         end else if (meta_interval_ff != '0) begin
            countdown_in = countdown_ff - INTERVAL_W'(1);
         end
      end

      if (csr_wr_en) begin
         countdown_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_interval_ff <= '0;
         countdown_ff     <= '0;
         remaining_ff     <= '0;
         scan_ff          <= SCAN_IDLE;
         pub_bank_ff      <= 1'b0;
         pub_len_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            meta_interval_ff <= csr_wr_data;
         end
         countdown_ff <= countdown_in;
         remaining_ff <= remaining_in;
         scan_ff      <= scan_in;
         pub_bank_ff  <= pub_bank_in;
         pub_len_ff   <= pub_len_in;
      end
   end

   // writes go to the staging bank, reads to the published one
   icy_md_title_store u_store (
      .clock    (clock),
      .title_wr (title_wr),
      .wr_go    (step && is_body && in_block),
      .rd_en    (step),
      .rd_bank  (pub_bank_ff),
      .rd_index (in_index_ff),
      .rd_char  (store_char)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         audio_valid_ff <= audio_in;
         audio_byte_ff  <= audio_in ? in_byte_ff : 8'd0;
         in_meta_ff     <= is_body && (in_block || len_byte);
         updated_ff     <= updated_in;
         title_len_ff   <= pub_len_in;
         char_ok_ff     <= (in_op_ff == OP_READ) && (in_index_ff < pub_len_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_audio_valid   = audio_valid_ff;
   assign rsp_audio_byte    = audio_byte_ff;
   assign rsp_in_metadata   = in_meta_ff;
   assign rsp_title_updated = updated_ff;
   assign rsp_title_length  = title_len_ff;
   assign rsp_title_char    = char_ok_ff ? store_char : 8'd0;

endmodule

`default_nettype wire

[hdl/icy_md_checker.sv]
`default_nettype none

module icy_md_checker
   import icy_md_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  csr_wr_en,
   input wire logic [INTERVAL_W-1:0] csr_wr_data,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  req_op,
   input wire logic [7:0]            req_data_byte,
   input wire logic [7:0]            req_title_index,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic                  rsp_audio_valid,
   input wire logic [7:0]            rsp_audio_byte,
   input wire logic                  rsp_in_metadata,
   input wire logic                  rsp_title_updated,
   input wire logic [7:0]            rsp_title_length,
   input wire logic [7:0]            rsp_title_char
);

   // a byte is either audio or metadata, never both
   a_audio_xor_meta: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_audio_valid && rsp_in_metadata))
      else $error("audio and metadata flagged together");

   a_audio_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_audio_valid) |-> (rsp_audio_byte == 8'd0))
      else $error("non-audio response carries a byte");

   a_update_in_meta: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_title_updated) |-> rsp_in_metadata)
      else $error("title update outside metadata");

   // a title character only comes back on a read request
   a_char_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_title_char != 8'd0) |->
         (!rsp_audio_valid && !rsp_in_metadata && !rsp_title_updated))
      else $error("title character on body byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_audio_byte) && $stable(rsp_title_length)
          && $stable(rsp_title_char)))
      else $error("stalled response changed");

endmodule

bind icy_metadata_demux_core icy_md_checker u_checker (.*);

`default_nettype wire
